// File: rtl/plf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plf_pkg
// Shared constants and types of the 2D principal-axis line fitter.
// ----------------------------------------------------------------------------
package plf_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 24;
  localparam int QUEUE_DEPTH    = 4;

  localparam int EXT_BITS   = 23;
  localparam int EXT_RESET  = 65536;
  localparam int USED_BITS  = 11;
  localparam int DIR_BITS   = 16;
  localparam int DIR_FRAC   = 14;
  localparam int DIR_ONE    = 16384;
  localparam int NORM_LIMIT = 536870912;
  localparam int SQ_W       = 64;

  typedef enum logic {
    ITEM_POINT,
    ITEM_CLOSE
  } item_kind_t;

  typedef struct packed {
    logic       valid;
    item_kind_t kind;
  } q_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage : plf_pkg
`default_nettype wire

// File: rtl/plf_point_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plf_point_if
// Point channel: one coordinate pair per item, with a group-close flag.
// ----------------------------------------------------------------------------
interface plf_point_if #(
  parameter int COORD_BITS = plf_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface : plf_point_if
`default_nettype wire

// File: rtl/plf_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plf_result_if
// Result channel: one fitted line per closed group.
// ----------------------------------------------------------------------------
interface plf_result_if #(
  parameter int COORD_BITS = plf_pkg::COORD_BITS_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic                                  fit_ok;
  logic                                  overflowed;
  logic [plf_pkg::USED_BITS-1:0]         used_points;
  logic signed [COORD_BITS-1:0]          mean_x;
  logic signed [COORD_BITS-1:0]          mean_y;
  logic signed [plf_pkg::DIR_BITS-1:0]   dir_x;
  logic signed [plf_pkg::DIR_BITS-1:0]   dir_y;
  logic signed [COORD_BITS+1:0]          raw_min;
  logic signed [COORD_BITS+1:0]          raw_max;
  logic signed [COORD_BITS+1:0]          ext_min;
  logic signed [COORD_BITS+1:0]          ext_max;

  modport source (output valid, fit_ok, overflowed, used_points, mean_x, mean_y,
                  dir_x, dir_y, raw_min, raw_max, ext_min, ext_max, input ready);
  modport sink   (input valid, fit_ok, overflowed, used_points, mean_x, mean_y,
                  dir_x, dir_y, raw_min, raw_max, ext_min, ext_max, output ready);
endinterface : plf_result_if
`default_nettype wire

// File: rtl/plf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plf_front
// Accepts points, tags group-closing items and queues them for the engine.
// ----------------------------------------------------------------------------
module plf_front #(
  parameter int COORD_BITS = plf_pkg::COORD_BITS_DEF,
  parameter int DEPTH      = plf_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  plf_point_if.sink                         points,
  output plf_pkg::q_ctl_t                   q_ctl,
  output logic signed [COORD_BITS-1:0]      q_x,
  output logic signed [COORD_BITS-1:0]      q_y,
  input  wire logic                         q_ready
);
  import plf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [COORD_BITS-1:0] x_mem [DEPTH];
  logic signed [COORD_BITS-1:0] y_mem [DEPTH];
  item_kind_t                   k_mem [DEPTH];
  logic [AW-1:0]                wr_ptr;
  logic [AW-1:0]                rd_ptr;
  logic [CW-1:0]                count;
  logic                         push;
  logic                         pop;

  assign points.ready = (count != CW'(DEPTH));
  assign push         = points.valid && points.ready;
  assign pop          = q_ctl.valid && q_ready;

  assign q_ctl.valid = (count != '0);
  assign q_ctl.kind  = k_mem[rd_ptr];
  assign q_x         = x_mem[rd_ptr];
  assign q_y         = y_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      x_mem[wr_ptr] <= points.point_x;
      y_mem[wr_ptr] <= points.point_y;
      k_mem[wr_ptr] <= points.last_point ? ITEM_CLOSE : ITEM_POINT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("queue push lost");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1) else $error("queue pop lost");
`endif

endmodule : plf_front
`default_nettype wire

// File: rtl/plf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plf_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plf_div #(
  parameter int NW = 48,
  parameter int DW = 33
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic [NW-1:0]      quo,
  output plf_pkg::unit_stat_t stat
);
  import plf_pkg::*;

  localparam int KW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [NW-1:0] q;
  logic [KW-1:0] cnt;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem, q[NW-1]};
  assign ge    = (trial >= {1'b0, dsr});
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        rem       <= '0;
        q         <= num;
        dsr       <= den;
        cnt       <= KW'(NW);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem <= ge ? DW'(trial - {1'b0, dsr}) : trial[DW-1:0];
        q   <= {q[NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == KW'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule : plf_div
`default_nettype wire

// File: rtl/plf_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plf_sqrt
// Integer square root, floor, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module plf_sqrt (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [plf_pkg::SQ_W-1:0] op,
  output logic [plf_pkg::SQ_W-1:0]      root,
  output plf_pkg::unit_stat_t           stat
);
  import plf_pkg::*;

  logic [SQ_W-1:0] v;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bt;
  logic [SQ_W-1:0] trial;
  logic            ge;

  assign trial = res + bt;
  assign ge    = (v >= trial);
  assign root  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        v         <= op;
        res       <= '0;
        bt        <= SQ_W'(1) << (SQ_W - 2);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        if (ge) begin
          v   <= v - trial;
          res <= (res >> 1) + bt;
        end else begin
          res <= res >> 1;
        end
        bt <= bt >> 2;
        if (bt == SQ_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule : plf_sqrt
`default_nettype wire

// File: rtl/plf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plf_back
// Fit engine: buffers and sums points, then mean, scatter, direction and
// projection passes over the buffer, and the result register.
// ----------------------------------------------------------------------------
module plf_back #(
  parameter int MAX_POINTS = plf_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = plf_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire plf_pkg::q_ctl_t               q_ctl,
  input  wire logic signed [COORD_BITS-1:0]  q_x,
  input  wire logic signed [COORD_BITS-1:0]  q_y,
  output logic                               q_ready,
  input  wire logic [plf_pkg::EXT_BITS-1:0]  ext_len,
  plf_result_if.source                       fits
);
  import plf_pkg::*;

  localparam int AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW      = $clog2(MAX_POINTS + 1);
  localparam int SUM_W   = COORD_BITS + CW;
  localparam int MN_W    = SUM_W + 2;
  localparam int DEN_W   = CW + 1;
  localparam int PRE_RAW = 2 * COORD_BITS + AW - 61;
  localparam int PRE     = (PRE_RAW > 0) ? (PRE_RAW + 1) / 2 : 0;
  localparam int DX_W    = COORD_BITS + 1;
  localparam int SDX_W   = DX_W - PRE;
  localparam int PR_W    = 2 * SDX_W;
  localparam int ACC_W   = PR_W + AW + 1;
  localparam int NE_W    = ACC_W + 2;
  localparam int MW      = 32;
  localparam int DIV_NW  = (MN_W > 48) ? MN_W : 48;
  localparam int DIV_DW  = (DEN_W > 33) ? DEN_W : 33;
  localparam int PX_W    = DX_W + DIR_BITS;
  localparam int P_W     = PX_W + 1;
  localparam int S_W     = P_W - DIR_FRAC;
  localparam int PROJ_W  = COORD_BITS + 2;
  localparam int E_W     = ((PROJ_W > EXT_BITS) ? PROJ_W : EXT_BITS) + 2;

  localparam logic signed [E_W-1:0] PROJ_HI =
    {{(E_W - PROJ_W + 1){1'b0}}, {(PROJ_W - 1){1'b1}}};
  localparam logic signed [E_W-1:0] PROJ_LO = ~PROJ_HI;

  typedef enum logic [4:0] {
    S_IDLE, S_CLOSE, S_MX_GO, S_MX_WAIT, S_MY_GO, S_MY_WAIT, S_COV, S_DE,
    S_MAG, S_NORM, S_SQ_D, S_SQ_E, S_RT_GO, S_RT_WAIT, S_VEC, S_VX2, S_VY2,
    S_LEN_GO, S_LEN_WAIT, S_DX_GO, S_DX_WAIT, S_DY_GO, S_DY_WAIT, S_SIGN,
    S_PROJ, S_OUT
  } state_t;

  function automatic logic signed [PROJ_W-1:0] sat_proj(
    input logic signed [E_W-1:0] v
  );
    logic signed [E_W-1:0] t;
    t = (v > PROJ_HI) ? PROJ_HI : ((v < PROJ_LO) ? PROJ_LO : v);
    return t[PROJ_W-1:0];
  endfunction

  state_t state;

  // point buffer
  logic signed [COORD_BITS-1:0] mem_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] mem_y [MAX_POINTS];
  logic signed [COORD_BITS-1:0] rd_x;
  logic signed [COORD_BITS-1:0] rd_y;
  logic                         pop;
  logic                         mem_we;

  logic [CW-1:0]                cnt;
  logic signed [SUM_W-1:0]      sum_x;
  logic signed [SUM_W-1:0]      sum_y;
  logic                         drop;
  logic                         fit_ok_r;

  logic signed [COORD_BITS-1:0] mx;
  logic signed [COORD_BITS-1:0] my;

  // pass pipeline
  logic [CW-1:0]                iss;
  logic                         pass_on;
  logic                         issue;
  logic                         v1, v2, v3, v4;
  logic                         pass_end;
  logic signed [DX_W-1:0]       dx, dy;
  logic signed [SDX_W-1:0]      sdx, sdy;
  logic signed [PR_W-1:0]       pa, pb, pc;
  logic signed [ACC_W-1:0]      acc_a, acc_b, acc_c;
  logic signed [PX_W-1:0]       px, py;
  logic signed [P_W-1:0]        psum;
  logic signed [S_W-1:0]        sv, smin, smax;
  logic                         first;

  // direction
  logic signed [NE_W-1:0]       dn, en;
  logic [NE_W-1:0]              mag;
  logic signed [NE_W-1:0]       abs_d, abs_e;
  logic signed [MW-1:0]         d_n, e_n;
  logic signed [MW-1:0]         vx, vy;
  logic [MW-1:0]                root_r, len;
  logic signed [MW-1:0]         mul_op;
  logic signed [2*MW-1:0]       prod;
  logic [SQ_W-1:0]              sq_a, sq_b;
  logic signed [DIR_BITS-1:0]   dir_x, dir_y;

  // shared units
  logic                         div_start;
  logic [DIV_NW-1:0]            div_num;
  logic [DIV_DW-1:0]            div_den;
  logic [DIV_NW-1:0]            div_quo;
  unit_stat_t                   div_stat;
  logic                         sq_start;
  logic [SQ_W-1:0]              sq_res;
  unit_stat_t                   sq_stat;

  logic signed [SUM_W-1:0]      msum;
  logic signed [MN_W-1:0]       mnum;
  logic [MN_W-1:0]              mmag;
  logic signed [COORD_BITS-1:0] mq;
  logic signed [COORD_BITS-1:0] mean_q;
  logic signed [MW-1:0]         vsel;
  logic [MW-1:0]                vabs;
  logic [DIR_BITS-1:0]          dq;
  logic signed [DIR_BITS-1:0]   dir_q;

  logic signed [PROJ_W-1:0]     rmin_s, rmax_s, emin_s, emax_s;

  assign q_ready = (state == S_IDLE);
  assign pop     = q_ctl.valid && q_ready;
  assign mem_we  = pop && (cnt != CW'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[cnt[AW-1:0]] <= q_x;
      mem_y[cnt[AW-1:0]] <= q_y;
    end
    rd_x <= mem_x[iss[AW-1:0]];
    rd_y <= mem_y[iss[AW-1:0]];
  end

  // mean: floor((2*sum + n) / 2n) on magnitudes
  assign msum   = (state == S_MX_GO || state == S_MX_WAIT) ? sum_x : sum_y;
  assign mnum   = (MN_W'(msum) <<< 1) + MN_W'(cnt);
  assign mmag   = mnum[MN_W-1] ? MN_W'(-mnum + (MN_W'(cnt) <<< 1) - 1)
                               : MN_W'(mnum);
  assign mq     = div_quo[COORD_BITS-1:0];
  assign mean_q = mnum[MN_W-1] ? -mq : mq;

  // unit direction component: round(|v| * 16384 / len), capped
  assign vsel  = (state == S_DX_GO || state == S_DX_WAIT) ? vx : vy;
  assign vabs  = vsel[MW-1] ? MW'(-vsel) : MW'(vsel);
  assign dq    = (div_quo > DIV_NW'(DIR_ONE)) ? DIR_BITS'(DIR_ONE)
                                              : div_quo[DIR_BITS-1:0];
  assign dir_q = vsel[MW-1] ? -$signed(dq) : $signed(dq);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state)
      S_MX_GO, S_MY_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(mmag);
        div_den   = DIV_DW'({cnt, 1'b0});
      end
      S_DX_GO, S_DY_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NW'({vabs, {(DIR_FRAC + 1){1'b0}}}) + DIV_NW'(len);
        div_den   = DIV_DW'({len, 1'b0});
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign sq_start = (state == S_RT_GO) || (state == S_LEN_GO);

  plf_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  plf_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .op    (sq_a + sq_b),
    .root  (sq_res),
    .stat  (sq_stat)
  );

  // one shared 32x32 squarer for the direction math
  always_comb begin
    unique case (state)
      S_SQ_D:  mul_op = d_n;
      S_SQ_E:  mul_op = e_n;
      S_VX2:   mul_op = vx;
      default: mul_op = vy;
    endcase
  end
  assign prod = mul_op * mul_op;

  assign d_n   = MW'(dn);
  assign e_n   = MW'(en);
  assign abs_d = dn[NE_W-1] ? -dn : dn;
  assign abs_e = en[NE_W-1] ? -en : en;

  // buffer walk shared by the scatter and projection passes
  assign pass_on  = (state == S_COV) || (state == S_PROJ);
  assign issue    = pass_on && (iss != cnt);
  assign pass_end = pass_on && (iss == cnt) && !v1 && !v2 && !v3 && !v4;
  assign sdx      = SDX_W'(dx >>> PRE);
  assign sdy      = SDX_W'(dy >>> PRE);
  assign psum     = P_W'(px) + P_W'(py) + P_W'(DIR_ONE / 2);

  always_ff @(posedge clk) begin
    dx <= DX_W'(rd_x) - DX_W'(mx);
    dy <= DX_W'(rd_y) - DX_W'(my);
    pa <= sdx * sdx;
    pb <= sdx * sdy;
    pc <= sdy * sdy;
    px <= dx * dir_x;
    py <= dy * dir_y;
    sv <= S_W'(psum >>> DIR_FRAC);
  end

  assign rmin_s = sat_proj(E_W'(smin));
  assign rmax_s = sat_proj(E_W'(smax));
  assign emin_s = sat_proj(E_W'(rmin_s) - E_W'(ext_len));
  assign emax_s = sat_proj(E_W'(rmax_s) + E_W'(ext_len));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      sum_x      <= '0;
      sum_y      <= '0;
      drop       <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      iss        <= '0;
      fits.valid <= 1'b0;
    end else begin
      if (fits.valid && fits.ready && state != S_OUT) begin
        fits.valid <= 1'b0;
      end
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (issue) begin
        iss <= iss + 1'b1;
      end
      if (state == S_COV && v3) begin
        acc_a <= acc_a + ACC_W'(pa);
        acc_b <= acc_b + ACC_W'(pb);
        acc_c <= acc_c + ACC_W'(pc);
      end
      if (state == S_PROJ && v4) begin
        first <= 1'b0;
        if (first || sv < smin) begin
          smin <= sv;
        end
        if (first || sv > smax) begin
          smax <= sv;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (mem_we) begin
              cnt   <= cnt + 1'b1;
              sum_x <= sum_x + SUM_W'(q_x);
              sum_y <= sum_y + SUM_W'(q_y);
            end else begin
              drop <= 1'b1;
            end
            if (q_ctl.kind == ITEM_CLOSE) begin
              state <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          if (cnt < CW'(2)) begin
            fit_ok_r <= 1'b0;
            state    <= S_OUT;
          end else begin
            fit_ok_r <= 1'b1;
            state    <= S_MX_GO;
          end
        end
        S_MX_GO:  state <= S_MX_WAIT;
        S_MX_WAIT: begin
          if (div_stat.done) begin
            mx    <= mean_q;
            state <= S_MY_GO;
          end
        end
        S_MY_GO:  state <= S_MY_WAIT;
        S_MY_WAIT: begin
          if (div_stat.done) begin
            my    <= mean_q;
            iss   <= '0;
            acc_a <= '0;
            acc_b <= '0;
            acc_c <= '0;
            state <= S_COV;
          end
        end
        S_COV: begin
          if (pass_end) begin
            state <= S_DE;
          end
        end
        S_DE: begin
          dn    <= NE_W'(acc_a) - NE_W'(acc_c);
          en    <= NE_W'(acc_b) <<< 1;
          state <= S_MAG;
        end
        S_MAG: begin
          mag   <= (abs_d > abs_e) ? NE_W'(abs_d) : NE_W'(abs_e);
          state <= S_NORM;
        end
        S_NORM: begin
          // floor-shift both terms one bit a cycle until they fit
          if (mag > NE_W'(NORM_LIMIT)) begin
            mag <= mag >> 1;
            dn  <= dn >>> 1;
            en  <= en >>> 1;
          end else if (dn == '0 && en == '0) begin
            dir_x <= DIR_BITS'(DIR_ONE);
            dir_y <= '0;
            iss   <= '0;
            first <= 1'b1;
            state <= S_PROJ;
          end else begin
            state <= S_SQ_D;
          end
        end
        S_SQ_D: begin
          sq_a  <= SQ_W'(prod);
          state <= S_SQ_E;
        end
        S_SQ_E: begin
          sq_b  <= SQ_W'(prod);
          state <= S_RT_GO;
        end
        S_RT_GO:  state <= S_RT_WAIT;
        S_RT_WAIT: begin
          if (sq_stat.done) begin
            root_r <= sq_res[MW-1:0];
            state  <= S_VEC;
          end
        end
        S_VEC: begin
          if (!d_n[MW-1]) begin
            vx <= d_n + $signed(root_r);
            vy <= e_n;
          end else begin
            vx <= e_n;
            vy <= $signed(root_r) - d_n;
          end
          state <= S_VX2;
        end
        S_VX2: begin
          sq_a  <= SQ_W'(prod);
          state <= S_VY2;
        end
        S_VY2: begin
          sq_b  <= SQ_W'(prod);
          state <= S_LEN_GO;
        end
        S_LEN_GO: state <= S_LEN_WAIT;
        S_LEN_WAIT: begin
          if (sq_stat.done) begin
            len   <= sq_res[MW-1:0];
            state <= S_DX_GO;
          end
        end
        S_DX_GO:  state <= S_DX_WAIT;
        S_DX_WAIT: begin
          if (div_stat.done) begin
            dir_x <= dir_q;
            state <= S_DY_GO;
          end
        end
        S_DY_GO:  state <= S_DY_WAIT;
        S_DY_WAIT: begin
          if (div_stat.done) begin
            dir_y <= dir_q;
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          // keep x positive, or y positive on a vertical line
          if (dir_x[DIR_BITS-1] || (dir_x == '0 && dir_y[DIR_BITS-1])) begin
            dir_x <= -dir_x;
            dir_y <= -dir_y;
          end
          iss   <= '0;
          first <= 1'b1;
          state <= S_PROJ;
        end
        S_PROJ: begin
          if (pass_end) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!fits.valid || fits.ready) begin
            fits.valid       <= 1'b1;
            fits.fit_ok      <= fit_ok_r;
            fits.overflowed  <= drop;
            fits.used_points <= USED_BITS'(cnt);
            fits.mean_x      <= fit_ok_r ? mx : '0;
            fits.mean_y      <= fit_ok_r ? my : '0;
            fits.dir_x       <= fit_ok_r ? dir_x : '0;
            fits.dir_y       <= fit_ok_r ? dir_y : '0;
            fits.raw_min     <= fit_ok_r ? rmin_s : '0;
            fits.raw_max     <= fit_ok_r ? rmax_s : '0;
            fits.ext_min     <= fit_ok_r ? emin_s : '0;
            fits.ext_max     <= fit_ok_r ? emax_s : '0;
            cnt              <= '0;
            sum_x            <= '0;
            sum_y            <= '0;
            drop             <= 1'b0;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule : plf_back
`default_nettype wire

// File: rtl/pca_line_fitter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pca_line_fitter_core
// Principal-axis line fit over groups of 2D points.
// ----------------------------------------------------------------------------
// A non-closing point enters the queue, which holds four items.
// A closing item of n points runs two walks over the buffer, four divisions,
// two square roots and the normalize steps; zero scatter skips the direction
// divisions and roots, and fewer than two points go straight to the result.
// One group is fitted at a time; a waiting result holds the engine.
// Synchronous reset clears the queue, the group sums and count and the
// result valid; ext_len returns to 65536. No buffer clearing pass.
module pca_line_fitter_core #(
  parameter int MAX_POINTS = plf_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = plf_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  plf_point_if.sink                         points,
  plf_result_if.source                      fits,
  input  wire logic                         ext_we,
  input  wire logic [plf_pkg::EXT_BITS-1:0] ext_wdata
);
  import plf_pkg::*;

  logic [EXT_BITS-1:0]          ext_len;
  q_ctl_t                       q_ctl;
  logic signed [COORD_BITS-1:0] q_x;
  logic signed [COORD_BITS-1:0] q_y;
  logic                         q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_len <= EXT_BITS'(EXT_RESET);
    end else if (ext_we) begin
      ext_len <= ext_wdata;
    end
  end

  plf_front #(.COORD_BITS(COORD_BITS), .DEPTH(QUEUE_DEPTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .points  (points),
    .q_ctl   (q_ctl),
    .q_x     (q_x),
    .q_y     (q_y),
    .q_ready (q_ready)
  );

  plf_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_ctl   (q_ctl),
    .q_x     (q_x),
    .q_y     (q_y),
    .q_ready (q_ready),
    .ext_len (ext_len),
    .fits    (fits)
  );

endmodule : pca_line_fitter_core
`default_nettype wire

// File: dv/plf_line_checker.sv
// ----------------------------------------------------------------------------
// plf_line_checker
// Watches the point and fit channels, predicts each fitted line from the
// accepted points and compares every fit item field by field.
// ----------------------------------------------------------------------------
module plf_line_checker #(
  parameter int MAX_POINTS = plf_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = plf_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pt_valid,
  input  logic                         pt_ready,
  input  logic signed [COORD_BITS-1:0] pt_x,
  input  logic signed [COORD_BITS-1:0] pt_y,
  input  logic                         pt_last,
  input  logic                         ft_valid,
  input  logic                         ft_ready,
  input  logic [6*COORD_BITS+52:0]     ft_flat,
  input  logic                         ext_we,
  input  logic [plf_pkg::EXT_BITS-1:0] ext_wdata,
  output int                           fail_count,
  output int                           pending_fits,
  output int                           fits_seen
);
  import plf_pkg::*;

  localparam int PW = COORD_BITS + 2;

  typedef struct packed {
    logic                    ok;
    logic                    ovf;
    logic [USED_BITS-1:0]    used;
    logic [COORD_BITS-1:0]   mx;
    logic [COORD_BITS-1:0]   my;
    logic [DIR_BITS-1:0]     dx;
    logic [DIR_BITS-1:0]     dy;
    logic [PW-1:0]           rmin;
    logic [PW-1:0]           rmax;
    logic [PW-1:0]           emin;
    logic [PW-1:0]           emax;
  } line_fit_t;

  longint grp_x[MAX_POINTS];
  longint grp_y[MAX_POINTS];
  int     grp_n;
  longint grp_sx, grp_sy;
  bit     grp_drop;
  longint ext_len;
  line_fit_t fit_queue[$];

  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint clamp_proj(longint v);
    longint hi;
    hi = (longint'(1) <<< (PW - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint unit_part(longint v, longint len);
    longint mag, q;
    mag = v < 0 ? -v : v;
    q = (2 * mag * DIR_ONE + len) / (2 * len);
    if (q > DIR_ONE) q = DIR_ONE;
    return v < 0 ? -q : q;
  endfunction

  function automatic line_fit_t fit_line();
    line_fit_t f;
    longint mx, my, a, b, c, d, e, m, vx, vy, r, len, dirx, diry;
    longint smin, smax, s, step;
    int lg, pre, k;
    f = '0;
    f.ovf = grp_drop;
    f.used = grp_n[USED_BITS-1:0];
    if (grp_n < 2) return f;
    f.ok = 1'b1;
    mx = fdiv(2 * grp_sx + grp_n, 2 * grp_n);
    my = fdiv(2 * grp_sy + grp_n, 2 * grp_n);
    lg = 0;
    while (lg < 32 && (longint'(1) << lg) < MAX_POINTS) lg++;
    pre = 0;
    if (2 * COORD_BITS + lg - 61 > 0) pre = (2 * COORD_BITS + lg - 61 + 1) / 2;
    step = longint'(1) << pre;
    a = 0; b = 0; c = 0;
    for (int i = 0; i < grp_n; i++) begin
      longint ux, uy;
      ux = fdiv(grp_x[i] - mx, step);
      uy = fdiv(grp_y[i] - my, step);
      a += ux * ux;
      c += uy * uy;
      b += ux * uy;
    end
    d = a - c;
    e = 2 * b;
    m = (d < 0 ? -d : d) > (e < 0 ? -e : e) ? (d < 0 ? -d : d) : (e < 0 ? -e : e);
    k = 0;
    while ((m >>> k) > NORM_LIMIT) k++;
    d = fdiv(d, longint'(1) << k);
    e = fdiv(e, longint'(1) << k);
    if (d == 0 && e == 0) begin
      dirx = DIR_ONE;
      diry = 0;
    end else begin
      r = int_sqrt(d * d + e * e);
      if (d >= 0) begin
        vx = d + r; vy = e;
      end else begin
        vx = e; vy = r - d;
      end
      len = int_sqrt(vx * vx + vy * vy);
      dirx = unit_part(vx, len);
      diry = unit_part(vy, len);
      if (dirx < 0 || (dirx == 0 && diry < 0)) begin
        dirx = -dirx;
        diry = -diry;
      end
    end
    smin = 0; smax = 0;
    for (int i = 0; i < grp_n; i++) begin
      s = fdiv((grp_x[i] - mx) * dirx + (grp_y[i] - my) * diry + DIR_ONE / 2, DIR_ONE);
      if (i == 0 || s < smin) smin = s;
      if (i == 0 || s > smax) smax = s;
    end
    smin = clamp_proj(smin);
    smax = clamp_proj(smax);
    f.mx = mx[COORD_BITS-1:0];
    f.my = my[COORD_BITS-1:0];
    f.dx = dirx[DIR_BITS-1:0];
    f.dy = diry[DIR_BITS-1:0];
    f.rmin = smin[PW-1:0];
    f.rmax = smax[PW-1:0];
    f.emin = PW'(clamp_proj(smin - ext_len));
    f.emax = PW'(clamp_proj(smax + ext_len));
    return f;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch on fit %0d: %s got %0h want %0h", fits_seen, what, got, want);
    fail_count++;
  endtask

  line_fit_t got_fit, want_fit;
  assign got_fit = ft_flat;

  always @(posedge clk) begin
    if (rst) begin
      grp_n = 0; grp_sx = 0; grp_sy = 0; grp_drop = 0;
      ext_len = EXT_RESET;
      fail_count = 0; fits_seen = 0;
      fit_queue.delete();
    end else begin
      if (ext_we) ext_len = ext_wdata;
      if (pt_valid && pt_ready) begin
        if (grp_n < MAX_POINTS) begin
          grp_x[grp_n] = pt_x;
          grp_y[grp_n] = pt_y;
          grp_n = grp_n + 1;
          grp_sx = grp_sx + pt_x;
          grp_sy = grp_sy + pt_y;
        end else begin
          grp_drop = 1;
        end
        if (pt_last) begin
          fit_queue.insert(fit_queue.size(), fit_line());
          grp_n = 0; grp_sx = 0; grp_sy = 0; grp_drop = 0;
        end
      end
      if (ft_valid && ft_ready) begin
        if (fit_queue.size() == 0) begin
          report("unexpected fit item", 1, 0);
        end else begin
          want_fit = fit_queue.pop_front();
          if (got_fit.ok != want_fit.ok) report("fit_ok", got_fit.ok, want_fit.ok);
          if (got_fit.ovf != want_fit.ovf) report("overflowed", got_fit.ovf, want_fit.ovf);
          if (got_fit.used != want_fit.used) report("used_points", got_fit.used, want_fit.used);
          if (got_fit.mx != want_fit.mx) report("mean_x", got_fit.mx, want_fit.mx);
          if (got_fit.my != want_fit.my) report("mean_y", got_fit.my, want_fit.my);
          if (got_fit.dx != want_fit.dx) report("dir_x", got_fit.dx, want_fit.dx);
          if (got_fit.dy != want_fit.dy) report("dir_y", got_fit.dy, want_fit.dy);
          if (got_fit.rmin != want_fit.rmin) report("raw_min", got_fit.rmin, want_fit.rmin);
          if (got_fit.rmax != want_fit.rmax) report("raw_max", got_fit.rmax, want_fit.rmax);
          if (got_fit.emin != want_fit.emin) report("ext_min", got_fit.emin, want_fit.emin);
          if (got_fit.emax != want_fit.emax) report("ext_max", got_fit.emax, want_fit.emax);
        end
        fits_seen = fits_seen + 1;
      end
    end
    pending_fits = fit_queue.size();
  end
endmodule

// File: dv/pca_line_fitter_core_tb.sv
// ----------------------------------------------------------------------------
// pca_line_fitter_core_tb
// Feeds point groups of many shapes and sizes, including single-point
// and overflowing groups, under random gaps and stalls and several extension
// lengths; the checker predicts and compares every fitted line.
// ----------------------------------------------------------------------------
module pca_line_fitter_core_tb;
  import plf_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 0;
  logic rst = 1;
  logic ext_we = 0;
  logic [EXT_BITS-1:0] ext_wdata = '0;
  logic sink_stall = 0;
  int   fail_count, pending_fits, fits_seen;
  longint cycle_count = 0;
  int   burst_left = 0;
  int   points_sent = 0;

  plf_point_if  #(.COORD_BITS(CB)) points ();
  plf_result_if #(.COORD_BITS(CB)) fits ();

  always #4 clk = ~clk;

  initial begin
    points.valid = 0;
    points.point_x = '0;
    points.point_y = '0;
    points.last_point = 0;
    fits.ready = 0;
  end

  pca_line_fitter_core #(.MAX_POINTS(MAX_POINTS_DEF), .COORD_BITS(CB)) u_top (
    .clk(clk), .rst(rst), .points(points), .fits(fits),
    .ext_we(ext_we), .ext_wdata(ext_wdata)
  );

  plf_line_checker #(.MAX_POINTS(MAX_POINTS_DEF), .COORD_BITS(CB)) u_checker (
    .clk(clk), .rst(rst),
    .pt_valid(points.valid), .pt_ready(points.ready),
    .pt_x(points.point_x), .pt_y(points.point_y), .pt_last(points.last_point),
    .ft_valid(fits.valid), .ft_ready(fits.ready),
    .ft_flat({fits.fit_ok, fits.overflowed, fits.used_points, fits.mean_x,
              fits.mean_y, fits.dir_x, fits.dir_y, fits.raw_min, fits.raw_max,
              fits.ext_min, fits.ext_max}),
    .ext_we(ext_we), .ext_wdata(ext_wdata),
    .fail_count(fail_count), .pending_fits(pending_fits), .fits_seen(fits_seen)
  );

  // receiver: long ready stretches alternate with stall patterns
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout");
      $display("simulation failed");
      $finish;
    end
    if (rst) fits.ready <= 0;
    else if (sink_stall) fits.ready <= ($urandom_range(0, 3) != 0);
    else fits.ready <= 1;
    if (cycle_count % 2000 == 0) sink_stall <= $urandom_range(0, 2) != 0;
  end

  task automatic send_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        points.valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    points.valid <= 1;
    points.point_x <= x;
    points.point_y <= y;
    points.last_point <= last;
    @(posedge clk);
    while (!points.ready) @(posedge clk);
    points_sent++;
  endtask

  task automatic go_idle();
    points.valid <= 0;
    @(posedge clk);
    while (pending_fits != 0) @(posedge clk);
    repeat (2 * MAX_POINTS_DEF + 400) @(posedge clk);
  endtask

  task automatic write_ext(logic [EXT_BITS-1:0] v);
    ext_we <= 1;
    ext_wdata <= v;
    @(posedge clk);
    ext_we <= 0;
  endtask

  function automatic logic signed [CB-1:0] rand_coord(int mode);
    case (mode)
      0: return CB'($urandom);
      1: return CB'($signed($urandom_range(0, 4095)) - 2048);
      default: return CB'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  // noisy line: points near a random direction through a random center, or in one mode of six scattered random points
  task automatic send_line_group(int n);
    int cx, cy, ax, ay, t, mode;
    cx = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    cy = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    ax = $signed($urandom_range(0, 2000)) - 1000;
    ay = $signed($urandom_range(0, 2000)) - 1000;
    mode = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      if (mode == 0) begin
        send_point(rand_coord($urandom_range(0, 2)), rand_coord($urandom_range(0, 2)),
                   i == n - 1);
      end else begin
        t = $signed($urandom_range(0, 4000)) - 2000;
        send_point(CB'(cx + t * ax + $signed($urandom_range(0, 512)) - 256),
                   CB'(cy + t * ay + $signed($urandom_range(0, 512)) - 256), i == n - 1);
      end
    end
  endtask

  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // single point, then a zero-scatter pair
    send_point(CMAX, CMIN, 1);
    send_point(0, 0, 0);
    send_point(0, 0, 1);
    // extremes and axis directions
    send_point(CMIN, CMIN, 0);
    send_point(CMAX, CMAX, 1);
    send_point(CMIN, CMAX, 0);
    send_point(CMAX, CMIN, 1);
    send_point(CMIN, 0, 0);
    send_point(CMAX, 0, 1);
    send_point(0, CMIN, 0);
    send_point(0, CMAX, 1);
    send_point(100, 100, 0);
    send_point(-100, 100, 0);
    send_point(100, -100, 0);
    send_point(-100, -100, 1);
    send_point(-1, -1, 0);
    send_point(1, 0, 0);
    send_point(0, 1, 1);
    go_idle();
    write_ext('0);
    send_line_group(5);
    go_idle();
    write_ext({EXT_BITS{1'b1}});
    send_point(CMAX, CMAX, 0);
    send_point(CMIN, CMIN, 1);
    send_line_group(8);
    go_idle();
    // overflowing group: one beyond capacity plus the closing point
    write_ext(EXT_BITS'(EXT_RESET));
    for (int i = 0; i < MAX_POINTS_DEF + 2; i++)
      send_point(rand_coord(2), rand_coord(2), i == MAX_POINTS_DEF + 1);
    go_idle();
    while (points_sent < 1750) begin
      if ($urandom_range(0, 9) == 0) begin
        go_idle();
        write_ext($urandom_range(0, 3) == 0 ? EXT_BITS'($urandom) : EXT_BITS'($urandom_range(0, 1 << 18)));
      end
      send_line_group($urandom_range(0, 7) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 24));
    end
    points.valid <= 0;
    @(posedge clk);
    while (pending_fits != 0) @(posedge clk);
    repeat (2 * MAX_POINTS_DEF + 400) @(posedge clk);
    $display("sent %0d points, checked %0d fitted lines across several extension lengths",
             points_sent, fits_seen);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
